// ===== sv/svpwm_pkg.sv =====
// Package for the space-vector PWM duty modulator.
// Holds the fixed-point widths, constants, register indexes, the result type and the division step.
// Depends on nothing; the top level imports it.
package svpwm_pkg;

	localparam int NUM_PH     = 3;
	localparam int PH_W       = 34;
	localparam int MAG_W      = 33;
	localparam int SPAN_W     = 34;
	localparam int REM_W      = 35;
	localparam int DIV_STEPS  = 30;
	localparam int P_W        = 32;
	localparam int SPAN2_W    = 32;
	localparam int K_W        = 16;
	localparam int KSPAN_W    = K_W + SPAN2_W;
	localparam int OFF_W      = 36;
	localparam int D_W        = 31;
	localparam int CNT_W      = 12;
	localparam int ONE_SHIFT  = 30;
	localparam int K_SHIFT    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [16:0] SQ3_Q15 = 17'd56756;
	localparam logic [SPAN_W-1:0] ONE_Q30 = SPAN_W'(1) << ONE_SHIFT;
	localparam logic [D_W-1:0] ONE_D = D_W'(1) << ONE_SHIFT;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SEQ_K = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_ENABLE = 2'd1;

	localparam logic [K_W-1:0] ZERO_SEQ_K_RESET = 16'd16384;

	typedef logic signed [PH_W-1:0] phase_t;
	typedef logic signed [P_W-1:0] scaled_t;

	typedef struct packed {
		logic [CNT_W-1:0] duty_a;
		logic [CNT_W-1:0] duty_b;
		logic [CNT_W-1:0] duty_c;
		logic             overmodulated;
	} result_t;

	// One restoring long-division step: the quotient bit is the top bit of the result.
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic [SPAN_W-1:0] dvs);
		logic [REM_W-1:0] sh;
		logic [REM_W-1:0] dx;
		sh = {rem[REM_W-2:0], 1'b0};
		dx = REM_W'(dvs);
		if (sh >= dx) begin
			return {1'b1, sh - dx};
		end else begin
			return {1'b0, sh};
		end
	endfunction

endpackage

// ===== sv/svpwm_duty_modulator.sv =====
// Space-vector PWM duty modulator with min/max zero-sequence injection.
// Inverse Clarke, overmodulation rescale by a pipelined divider, offset, clamp and scaling.
// Depends on svpwm_pkg.
//
// Usage:
// The vector channel (vec_valid, vec_ready, volt_alpha, volt_beta) takes one
// alpha/beta beat per cycle while vec_ready is high. The duty channel
// (duty_valid, duty_ready, duty_a, duty_b, duty_c, overmodulated) returns one
// beat for each vector, in order. The pipeline depth comes from the 30-step
// restoring divider that rescales overmodulated vectors, plus ten stages for
// the transform, span, offset, clamp and count multiply.
// A two-entry output buffer holds finished results; the pipeline advances while
// that buffer has a free entry, so a vector is still taken while one result waits.
// When the receiver stalls long enough to fill the buffer, vec_ready falls and
// the pipeline freezes in place without losing or repeating a beat.
// Reset clears all valid bits and the buffer, sets zero_seq_k to 0.5 and
// disarms the outputs. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata only while no vector is in flight; the block does not enforce it.
module svpwm_duty_modulator
	import svpwm_pkg::*;
#(
	parameter int PWM_MAX_COUNT = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  vec_valid,
	output logic                  vec_ready,
	input  logic signed [15:0]    volt_alpha,
	input  logic signed [15:0]    volt_beta,
	output logic                  duty_valid,
	input  logic                  duty_ready,
	output logic [CNT_W-1:0]      duty_a,
	output logic [CNT_W-1:0]      duty_b,
	output logic [CNT_W-1:0]      duty_c,
	output logic                  overmodulated
);

	localparam int PWM_W = $clog2(PWM_MAX_COUNT + 1);
	localparam int PROD_W = D_W + PWM_W;
	localparam logic [PWM_W-1:0] PWM_MAX = PWM_W'(PWM_MAX_COUNT);

	logic [K_W-1:0] zero_seq_k_q;
	logic           arm_enable_q;
	logic           en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seq_k_q <= ZERO_SEQ_K_RESET;
			arm_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ZERO_SEQ_K: zero_seq_k_q <= cfg_wdata[K_W-1:0];
				CFG_ARM_ENABLE: arm_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Stage 1: inverse Clarke.
	logic signed [32:0] beta_prod;
	phase_t             alpha16;
	phase_t             alpha15;
	phase_t             beta_ext;
	logic               v_s1;
	phase_t             ph_s1 [NUM_PH];

	assign beta_prod = $signed(SQ3_Q15) * volt_beta;
	assign alpha16 = {{2{volt_alpha[15]}}, volt_alpha, 16'd0};
	assign alpha15 = {{3{volt_alpha[15]}}, volt_alpha, 15'd0};
	assign beta_ext = {beta_prod[32], beta_prod};

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1[0] <= alpha16;
			ph_s1[1] <= beta_ext - alpha15;
			ph_s1[2] <= -alpha15 - beta_ext;
		end
	end

	// Stage 2: max and min of the phases.
	logic   v_s2;
	phase_t ph_s2 [NUM_PH];
	phase_t vmax_s2;
	phase_t vmin_s2;
	phase_t vmax_w;
	phase_t vmin_w;

	always_comb begin
		vmax_w = ph_s1[0];
		vmin_w = ph_s1[0];
		for (int i = 1; i < NUM_PH; i++) begin
			if (ph_s1[i] > vmax_w) vmax_w = ph_s1[i];
			if (ph_s1[i] < vmin_w) vmin_w = ph_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s2   <= ph_s1;
			vmax_s2 <= vmax_w;
			vmin_s2 <= vmin_w;
		end
	end

	// Stage 3: span, overmodulation check, divisor and phase magnitudes.
	logic              v_s3;
	logic              over_s3;
	logic [SPAN_W-1:0] dvs_s3;
	logic              neg_s3 [NUM_PH];
	logic [MAG_W-1:0]  mag_s3 [NUM_PH];
	logic [SPAN_W-1:0] span_w;
	logic              over_w;

	assign span_w = SPAN_W'($unsigned(vmax_s2) - $unsigned(vmin_s2));
	assign over_w = span_w > ONE_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			over_s3 <= over_w;
			dvs_s3  <= over_w ? span_w : ONE_Q30;
			for (int i = 0; i < NUM_PH; i++) begin
				neg_s3[i] <= ph_s2[i][PH_W-1];
				mag_s3[i] <= MAG_W'(ph_s2[i][PH_W-1] ? -ph_s2[i] : ph_s2[i]);
			end
		end
	end

	// Stage 4: restoring divider, one quotient bit per step. Without overmodulation
	// the divisor is 1.0, so the quotient equals the magnitude.
	logic                 v_s4    [DIV_STEPS];
	logic                 over_s4 [DIV_STEPS];
	logic [SPAN_W-1:0]    dvs_s4  [DIV_STEPS];
	logic                 neg_s4  [DIV_STEPS][NUM_PH];
	logic [REM_W-1:0]     rem_s4  [DIV_STEPS][NUM_PH];
	logic [DIV_STEPS-1:0] quo_s4  [DIV_STEPS][NUM_PH];

	always_ff @(posedge clk) begin
		logic [REM_W:0] st;
		if (en) begin
			over_s4[0] <= over_s3;
			dvs_s4[0]  <= dvs_s3;
			for (int i = 0; i < NUM_PH; i++) begin
				st = div_step(REM_W'(mag_s3[i]), dvs_s3);
				neg_s4[0][i] <= neg_s3[i];
				rem_s4[0][i] <= st[REM_W-1:0];
				quo_s4[0][i] <= DIV_STEPS'(st[REM_W]);
			end
			for (int j = 1; j < DIV_STEPS; j++) begin
				over_s4[j] <= over_s4[j-1];
				dvs_s4[j]  <= dvs_s4[j-1];
				for (int i = 0; i < NUM_PH; i++) begin
					st = div_step(rem_s4[j-1][i], dvs_s4[j-1]);
					neg_s4[j][i] <= neg_s4[j-1][i];
					rem_s4[j][i] <= st[REM_W-1:0];
					quo_s4[j][i] <= {quo_s4[j-1][i][DIV_STEPS-2:0], st[REM_W]};
				end
			end
		end
	end

	// Stage 5: signed floor quotient.
	logic    v_s5;
	logic    over_s5;
	scaled_t p_s5 [NUM_PH];

	always_ff @(posedge clk) begin
		scaled_t qx;
		if (en) begin
			over_s5 <= over_s4[DIV_STEPS-1];
			for (int i = 0; i < NUM_PH; i++) begin
				qx = P_W'(quo_s4[DIV_STEPS-1][i]);
				if (neg_s4[DIV_STEPS-1][i]) begin
					p_s5[i] <= -(qx + P_W'(rem_s4[DIV_STEPS-1][i] != '0));
				end else begin
					p_s5[i] <= qx;
				end
			end
		end
	end

	// Stage 6: max and min of the scaled phases.
	logic    v_s6;
	logic    over_s6;
	scaled_t p_s6 [NUM_PH];
	scaled_t vmax_s6;
	scaled_t vmin_s6;
	scaled_t pmax_w;
	scaled_t pmin_w;

	always_comb begin
		pmax_w = p_s5[0];
		pmin_w = p_s5[0];
		for (int i = 1; i < NUM_PH; i++) begin
			if (p_s5[i] > pmax_w) pmax_w = p_s5[i];
			if (p_s5[i] < pmin_w) pmin_w = p_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			over_s6 <= over_s5;
			p_s6    <= p_s5;
			vmax_s6 <= pmax_w;
			vmin_s6 <= pmin_w;
		end
	end

	// Stage 7: scaled span.
	logic               v_s7;
	logic               over_s7;
	scaled_t            p_s7 [NUM_PH];
	scaled_t            vmin_s7;
	logic [SPAN2_W-1:0] span2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			over_s7  <= over_s6;
			p_s7     <= p_s6;
			vmin_s7  <= vmin_s6;
			span2_s7 <= SPAN2_W'($unsigned(vmax_s6) - $unsigned(vmin_s6));
		end
	end

	// Stage 8: k times span.
	logic               v_s8;
	logic               over_s8;
	scaled_t            p_s8 [NUM_PH];
	scaled_t            vmin_s8;
	logic [KSPAN_W-1:0] kspan_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			over_s8  <= over_s7;
			p_s8     <= p_s7;
			vmin_s8  <= vmin_s7;
			kspan_s8 <= KSPAN_W'(zero_seq_k_q) * KSPAN_W'(span2_s7);
		end
	end

	// Stage 9: zero-sequence offset.
	logic                    v_s9;
	logic                    over_s9;
	scaled_t                 p_s9 [NUM_PH];
	logic signed [OFF_W-1:0] off_s9;
	logic signed [OFF_W-1:0] k_term;
	logic signed [OFF_W-1:0] ks_term;
	logic signed [OFF_W-1:0] vmin_term;

	assign k_term    = $signed(OFF_W'({zero_seq_k_q, 15'd0}));
	assign ks_term   = $signed(OFF_W'(kspan_s8 >> K_SHIFT));
	assign vmin_term = OFF_W'(vmin_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			over_s9 <= over_s8;
			p_s9    <= p_s8;
			off_s9  <= k_term - vmin_term - ks_term;
		end
	end

	// Stage 10: add offset and clamp to [0, 1.0].
	logic           v_s10;
	logic           over_s10;
	logic [D_W-1:0] d_s10 [NUM_PH];

	always_ff @(posedge clk) begin
		logic signed [OFF_W-1:0] sum;
		if (en) begin
			over_s10 <= over_s9;
			for (int i = 0; i < NUM_PH; i++) begin
				sum = OFF_W'(p_s9[i]) + off_s9;
				if (sum < 0) begin
					d_s10[i] <= '0;
				end else if (sum > $signed(OFF_W'(ONE_D))) begin
					d_s10[i] <= ONE_D;
				end else begin
					d_s10[i] <= D_W'(sum);
				end
			end
		end
	end

	// Stage 11: scale to PWM counts.
	logic              v_s11;
	logic              over_s11;
	logic [PROD_W-1:0] prod_s11 [NUM_PH];

	always_ff @(posedge clk) begin
		if (en) begin
			over_s11 <= over_s10;
			for (int i = 0; i < NUM_PH; i++) begin
				prod_s11[i] <= PROD_W'(d_s10[i]) * PROD_W'(PWM_MAX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				v_s4[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= vec_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4[0] <= v_s3;
			for (int j = 1; j < DIV_STEPS; j++) begin
				v_s4[j] <= v_s4[j-1];
			end
			v_s5  <= v_s4[DIV_STEPS-1];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Output buffer: the head drives the port, the spare catches a beat during a stall.
	result_t tail_res;
	result_t head_q;
	result_t spare_q;
	logic    head_valid_q;
	logic    spare_valid_q;
	logic    push;
	logic    pop;

	always_comb begin
		tail_res.duty_a = arm_enable_q ? CNT_W'(prod_s11[0] >> ONE_SHIFT) : '0;
		tail_res.duty_b = arm_enable_q ? CNT_W'(prod_s11[1] >> ONE_SHIFT) : '0;
		tail_res.duty_c = arm_enable_q ? CNT_W'(prod_s11[2] >> ONE_SHIFT) : '0;
		tail_res.overmodulated = over_s11;
	end

	assign en   = !(head_valid_q && spare_valid_q);
	assign push = v_s11 && en;
	assign pop  = head_valid_q && duty_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			priority if (push && (pop || !head_valid_q)) begin
				head_valid_q <= 1'b1;
			end else if (push) begin
				spare_valid_q <= 1'b1;
			end else if (pop && spare_valid_q) begin
				spare_valid_q <= 1'b0;
			end else if (pop) begin
				head_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && (pop || !head_valid_q)) begin
			head_q <= tail_res;
		end else if (push) begin
			spare_q <= tail_res;
		end else if (pop && spare_valid_q) begin
			head_q <= spare_q;
		end
	end

	assign vec_ready     = en;
	assign duty_valid    = head_valid_q;
	assign duty_a        = head_q.duty_a;
	assign duty_b        = head_q.duty_b;
	assign duty_c        = head_q.duty_c;
	assign overmodulated = head_q.overmodulated;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vec_ready |-> duty_valid)
		else $error("pipeline stalled while the output buffer had room");

	a_spare_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> head_valid_q)
		else $error("spare entry valid without a valid head");

	a_exact_when_not_over: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4[DIV_STEPS-1] && !over_s4[DIV_STEPS-1] |->
		rem_s4[DIV_STEPS-1][0] == '0 && rem_s4[DIV_STEPS-1][1] == '0 &&
		rem_s4[DIV_STEPS-1][2] == '0)
		else $error("unit divisor left a remainder");

	a_disarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && !arm_enable_q |=>
		(spare_valid_q ? spare_q.duty_a : head_q.duty_a) == '0)
		else $error("duty count nonzero while disarmed");

endmodule

// ===== bench/svpwm_duty_checker.sv =====
// Checker for the space-vector PWM duty modulator: watches the config, vector and duty ports,
// predicts each duty beat in fixed point and compares it with what the block returns.
// Depends on svpwm_pkg; instantiated by tb_top beside the block.
module svpwm_duty_checker
	import svpwm_pkg::*;
#(
	parameter int PWM_MAX_COUNT = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  vec_valid,
	input  logic                  vec_ready,
	input  logic signed [15:0]    volt_alpha,
	input  logic signed [15:0]    volt_beta,
	input  logic                  duty_valid,
	input  logic                  duty_ready,
	input  logic [CNT_W-1:0]      duty_a,
	input  logic [CNT_W-1:0]      duty_b,
	input  logic [CNT_W-1:0]      duty_c,
	input  logic                  overmodulated,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint FULL_Q30 = longint'(1) << 30;

	logic [K_W-1:0] zsk_copy = ZERO_SEQ_K_RESET;
	logic           armed_copy = 1'b0;
	result_t        duty_exp_q[$];
	result_t        oldest;
	int             fails = 0;
	int             outstanding = 0;

	assign fail_count = fails;
	assign pending = outstanding;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: duty mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d != 0) && (n < 0)) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic longint phase_span(input longint ph[3], output longint lo);
		longint hi;
		hi = ph[0];
		lo = ph[0];
		for (int i = 1; i < 3; i++) begin
			if (ph[i] > hi) hi = ph[i];
			if (ph[i] < lo) lo = ph[i];
		end
		return hi - lo;
	endfunction

	function automatic logic [CNT_W-1:0] to_count(input longint v);
		longint d;
		d = (v < 0) ? 0 : ((v > FULL_Q30) ? FULL_Q30 : v);
		return CNT_W'((d * PWM_MAX_COUNT) >>> 30);
	endfunction

	// Inverse Clarke in Q30, rescale when the span exceeds one, then min/max offset injection.
	function automatic result_t predict_duties(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic [K_W-1:0] k, input logic arm);
		longint  ph[3];
		longint  lo;
		longint  span;
		longint  offset;
		result_t r;
		ph[0] = longint'(a) * 65536;
		ph[1] = -longint'(a) * 32768 + longint'(SQ3_Q15) * longint'(b);
		ph[2] = -longint'(a) * 32768 - longint'(SQ3_Q15) * longint'(b);
		span = phase_span(ph, lo);
		r.overmodulated = (span > FULL_Q30);
		if (r.overmodulated) begin
			for (int i = 0; i < 3; i++) begin
				ph[i] = floor_quot(ph[i] * FULL_Q30, span);
			end
			span = phase_span(ph, lo);
		end
		offset = longint'(k) * 32768 - lo - ((longint'(k) * span) >>> 15);
		r.duty_a = arm ? to_count(ph[0] + offset) : '0;
		r.duty_b = arm ? to_count(ph[1] + offset) : '0;
		r.duty_c = arm ? to_count(ph[2] + offset) : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zsk_copy <= ZERO_SEQ_K_RESET;
			armed_copy <= 1'b0;
			duty_exp_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ZERO_SEQ_K) begin
					zsk_copy <= cfg_wdata;
				end else if (cfg_index == CFG_ARM_ENABLE) begin
					armed_copy <= cfg_wdata[0];
				end
			end
			if (vec_valid && vec_ready) begin
				duty_exp_q.push_back(predict_duties(volt_alpha, volt_beta, zsk_copy,
					armed_copy));
			end
			if (duty_valid && duty_ready) begin
				if (duty_exp_q.size() == 0) begin
					report_mismatch("duty beat arrived with no vector outstanding");
				end else begin
					oldest = duty_exp_q.pop_front();
					check_field("duty_a", duty_a, oldest.duty_a);
					check_field("duty_b", duty_b, oldest.duty_b);
					check_field("duty_c", duty_c, oldest.duty_c);
					check_field("overmodulated", overmodulated, oldest.overmodulated);
				end
			end
			outstanding <= duty_exp_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the duty modulator bench: clock, reset, register settings, vector stimulus
// and a randomly stalling duty receiver. Depends on svpwm_pkg, the block and
// svpwm_duty_checker, which predicts and compares every duty beat.
module tb_top
	import svpwm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PWM_COUNT_MAX = 4095;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 192;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  vec_valid = 1'b0;
	logic                  vec_ready;
	logic signed [15:0]    volt_alpha = '0;
	logic signed [15:0]    volt_beta = '0;
	logic                  duty_valid;
	logic                  duty_ready = 1'b0;
	logic [CNT_W-1:0]      duty_a;
	logic [CNT_W-1:0]      duty_b;
	logic [CNT_W-1:0]      duty_c;
	logic                  overmodulated;
	int                    fail_count;
	int                    pending;
	int                    vectors_sent = 0;

	int dir_vec[20][2] = '{
		'{0, 0}, '{1, 0}, '{0, 1}, '{-1, -1},
		'{32767, 32767}, '{-32768, -32768}, '{32767, -32768}, '{-32768, 32767},
		'{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32768},
		'{16384, 0}, '{-16384, 0}, '{0, 16384}, '{0, -16384},
		'{10922, 0}, '{10923, 0}, '{0, 9459}, '{0, -9460}
	};
	logic [K_W-1:0] phase_k[NUM_PHASES] = '{16'd16384, 16'd0, 16'd32768, 16'd65535,
		16'd16384, 16'd0, 16'd0, 16'd8192};
	logic phase_arm[NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

	svpwm_duty_modulator #(.PWM_MAX_COUNT(PWM_COUNT_MAX)) dut (.*);

	svpwm_duty_checker #(.PWM_MAX_COUNT(PWM_COUNT_MAX)) duty_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [K_W-1:0] k, input logic arm);
		logic [CFG_DATA_W-1:0] arm_word;
		arm_word = 16'($urandom);
		arm_word[0] = arm;
		write_reg(CFG_ZERO_SEQ_K, k);
		write_reg(CFG_ARM_ENABLE, arm_word);
		write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic send_vector(input logic signed [15:0] a, input logic signed [15:0] b);
		if (!(vectors_sent >= 600 && vectors_sent < 900) && $urandom_range(0, 99) < 25) begin
			vec_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		vec_valid <= 1'b1;
		volt_alpha <= a;
		volt_beta <= b;
		do @(posedge clk); while (!vec_ready);
		vectors_sent++;
	endtask

	task automatic pick_vector(output logic signed [15:0] a, output logic signed [15:0] b);
		int sel;
		int corner[4] = '{-32768, 32767, 0, -1};
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			a = 16'($urandom);
			b = 16'($urandom);
		end else if (sel < 70) begin
			a = 16'(int'($urandom_range(0, 22000)) - 11000);
			b = 16'(int'($urandom_range(0, 22000)) - 11000);
		end else if (sel < 85) begin
			a = 16'(int'($urandom_range(0, 4000)) - 2000);
			b = 16'(int'($urandom_range(0, 4000)) - 2000);
		end else begin
			a = 16'(corner[$urandom_range(0, 3)]);
			b = 16'(corner[$urandom_range(0, 3)]);
		end
	endtask

	initial begin : receiver
		int beats;
		int hold;
		beats = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (duty_valid && duty_ready) begin
				beats++;
				if (beats == 300 || beats == 1100) begin
					hold = 150;
				end
			end
			if (hold > 0) begin
				duty_ready <= 1'b0;
				hold--;
			end else if (beats >= 600 && beats < 900) begin
				duty_ready <= 1'b1;
			end else begin
				duty_ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	initial begin : stimulus
		logic signed [15:0] a;
		logic signed [15:0] b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_setting(ZERO_SEQ_K_RESET, 1'b1);
		foreach (dir_vec[i]) begin
			send_vector(16'(dir_vec[i][0]), 16'(dir_vec[i][1]));
		end
		phase_k[5] = 16'($urandom_range(0, 32768));
		phase_k[6] = 16'($urandom);
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			apply_setting(phase_k[p], phase_arm[p]);
			repeat (PHASE_ITEMS) begin
				pick_vector(a, b);
				send_vector(a, b);
			end
		end
		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/svpwm_pkg.sv
sv/svpwm_duty_modulator.sv
bench/svpwm_duty_checker.sv
bench/tb_top.sv
